// ----- rtl/core/ard_pkg.sv -----
// Shared types and constants for the address region decoder.
package ard_pkg;

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 33;
	localparam int IDX_W  = 3;

	localparam logic [SIZE_W-1:0] SIZE_LIMIT = 33'h1_0000_0000;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	// result register load select
	localparam logic [1:0] RES_NONE = 2'd0;
	localparam logic [1:0] RES_FAIL = 2'd1;
	localparam logic [1:0] RES_ADD  = 2'd2;
	localparam logic [1:0] RES_HIT  = 2'd3;

	typedef struct packed {
		logic       load;
		logic       issue;
		logic [1:0] res_sel;
	} ard_cmd_t;

	typedef struct packed {
		logic is_add;
		logic full;
		logic empty;
		logic cmp_vld;
		logic match;
		logic cmp_last;
		logic can_issue;
	} ard_status_t;

endpackage

// ----- rtl/core/ard_ram.sv -----
// Generic single-port-write, registered-read RAM.
module ard_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/ard_ctrl.sv -----
// Controller state machine: sequences the region table scan.
module ard_ctrl
	import ard_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  ard_status_t st,
	output ard_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_RESP  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.issue   = 1'b0;
		cmd.res_sel = RES_NONE;
		case (state_q)
			S_IDLE, S_RESP: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_CHECK: begin
				if (st.is_add && st.full) begin
					cmd.res_sel = RES_FAIL;
					state_d     = S_RESP;
				end else if (st.empty) begin
					cmd.res_sel = st.is_add ? RES_ADD : RES_FAIL;
					state_d     = S_RESP;
				end else begin
					cmd.issue = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.cmp_vld && st.match) begin
					cmd.res_sel = st.is_add ? RES_FAIL : RES_HIT;
					state_d     = S_RESP;
				end else if (st.cmp_vld && st.cmp_last) begin
					cmd.res_sel = st.is_add ? RES_ADD : RES_FAIL;
					state_d     = S_RESP;
				end else begin
					cmd.issue = st.can_issue;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == S_CHECK) || (state_q == S_SCAN);
	assign done = (state_q == S_RESP);

endmodule

// ----- rtl/core/ard_dp.sv -----
// Datapath: operand registers, region table, range compare, result registers.
module ard_dp
	import ard_pkg::*;
#(
	parameter int MAX_REGIONS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              func,
	input  logic [ADDR_W-1:0] address,
	input  logic [SIZE_W-1:0] region_size,
	input  ard_cmd_t          cmd,
	output ard_status_t       st,
	output logic              ok,
	output logic [IDX_W-1:0]  region_index,
	output logic [ADDR_W-1:0] offset
);

	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam int EW = ADDR_W + SIZE_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	logic              func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] size_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_cnt_q;
	logic              cmp_vld_s1;
	logic [CW-1:0]     cmp_idx_s1;
	logic              res_ok_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [ADDR_W-1:0] res_off_q;

	logic              wr_en;
	logic [EW-1:0]     rd_data;
	logic [ADDR_W-1:0] b;
	logic [SIZE_W-1:0] l;
	logic [SIZE_W-1:0] a_end;
	logic [SIZE_W-1:0] b_end;
	logic              base_in_new;
	logic              addr_in_old;

	assign wr_en = (cmd.res_sel == RES_ADD);

	ard_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_REGIONS)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[IW-1:0]),
		.wdata({addr_q, size_q}),
		.raddr(rd_cnt_q[IW-1:0]),
		.rdata(rd_data)
	);

	assign b     = rd_data[EW-1:SIZE_W];
	assign l     = rd_data[SIZE_W-1:0];
	assign a_end = {1'b0, addr_q} + size_q;
	assign b_end = {1'b0, b} + l;

	assign base_in_new = (b >= addr_q) && ({1'b0, b} < a_end);
	assign addr_in_old = (addr_q >= b) && ({1'b0, addr_q} < b_end);

	assign st.is_add    = (func_q == FUNC_ADD);
	assign st.full      = (count_q == MAX_CNT);
	assign st.empty     = (count_q == '0);
	assign st.cmp_vld   = cmp_vld_s1;
	assign st.match     = addr_in_old || (st.is_add && base_in_new);
	assign st.cmp_last  = (cmp_idx_s1 == count_q - CNT_ONE);
	assign st.can_issue = (rd_cnt_q < count_q);

	// operand capture; oversized lengths saturate to SIZE_LIMIT, the size of the address space
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			addr_q <= address;
			size_q <= (region_size > SIZE_LIMIT) ? SIZE_LIMIT : region_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_cnt_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				count_q <= count_q + CNT_ONE;
			end
			if (cmd.load) begin
				rd_cnt_q <= '0;
			end else if (cmd.issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_ONE;
			end
			cmp_vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			cmp_idx_s1 <= rd_cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			RES_FAIL: begin
				res_ok_q  <= 1'b0;
				res_idx_q <= '0;
				res_off_q <= '0;
			end
			RES_ADD: begin
				res_ok_q  <= 1'b1;
				res_idx_q <= IDX_W'(count_q);
				res_off_q <= '0;
			end
			RES_HIT: begin
				res_ok_q  <= 1'b1;
				res_idx_q <= IDX_W'(cmp_idx_s1);
				res_off_q <= addr_q - b;
			end
			default: begin
			end
		endcase
	end

	assign ok           = res_ok_q;
	assign region_index = res_idx_q;
	assign offset       = res_off_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("region count above table depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !st.full)
		else $error("table write while full");

	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (cmp_idx_s1 < count_q))
		else $error("compare of an unwritten slot");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (rd_cnt_q < count_q))
		else $error("read issued past region count");

endmodule

// ----- rtl/core/address_region_decoder.sv -----
// Top level of the address region decoder.
// Usage:
//   A transaction is taken when start is high and busy is low; func, address
//   and region_size are sampled at that edge. func = 0 adds a region
//   [address, address + region_size), func = 1 decodes address.
//   Each transaction gives one result: done is high for one cycle with ok,
//   region_index and offset valid in that cycle. The receiver cannot stall.
//   Sequence: the accepting edge loads the operands and enters a check state;
//   a full-table add or an empty table gives the result straight from there,
//   otherwise the stored regions are compared in index order, stopping early
//   on a hit or overlap, and the result is registered when the scan ends.
//   The table is read one entry per cycle from a registered RAM; busy is
//   low in the done cycle, so the next transaction may start there.
//   Reset clears the region count; table contents are never compared before
//   they are written.
module address_region_decoder
	import ard_pkg::*;
#(
	parameter int MAX_REGIONS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [ADDR_W-1:0] address,
	input  logic [SIZE_W-1:0] region_size,
	output logic              done,
	output logic              ok,
	output logic [IDX_W-1:0]  region_index,
	output logic [ADDR_W-1:0] offset
);

	ard_cmd_t    cmd;
	ard_status_t st;

	ard_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	ard_dp #(
		.MAX_REGIONS(MAX_REGIONS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.address     (address),
		.region_size (region_size),
		.cmd         (cmd),
		.st          (st),
		.ok          (ok),
		.region_index(region_index),
		.offset      (offset)
	);

endmodule
